>>> rtl/b64e_pkg.sv
`timescale 1ns / 1ps
package b64e_pkg;

	localparam int unsigned QueueDepth = 2;

	// one classified byte: up to two 6-bit codes waiting for the back part
	typedef struct packed {
		logic [5:0] six0;
		logic [5:0] six1;
		logic       pair;
		logic       eot;
	} q_entry_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic second_half;
	} back_status_t;

	localparam logic [1:0] PhaseFirst  = 2'd0;
	localparam logic [1:0] PhaseSecond = 2'd1;
	localparam logic [1:0] PhaseThird  = 2'd2;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [6:0] b64e_char(input logic [5:0] six);
		logic [6:0] code;
		if (six < 6'd26) begin
			code = {1'b0, six} + 7'd65;
		end else if (six < 6'd52) begin
			code = {1'b0, six} + 7'd71;
		end else if (six < 6'd62) begin
			code = {1'b0, six} - 7'd4;
		end else if (six == 6'd62) begin
			code = 7'd43;
		end else begin
			code = 7'd47;
		end
		return code;
	endfunction

endpackage

>>> rtl/b64e_if.sv
`timescale 1ns / 1ps
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

>>> rtl/base64_unpadded_encoder_top.sv
`timescale 1ns / 1ps
// unpadded base64 encoder
// bytes: valid/ready request channel carrying data_byte and is_last; is_last
//   marks the final byte of a message and flushes any leftover bits as one
//   more character, zero filled at the bottom
// chars: valid/ready request channel carrying char_code (ASCII) and
//   end_of_text, set only on the last character of a message
// a byte makes one character, or two on the third byte of a group or on a
//   last byte; no '=' padding is ever produced
// order: a taken byte is written into the queue, then loaded from the queue head
//   into the output register, and a second character then from the same entry
// throughput: one character per cycle out of the output register while chars
//   is ready, so a byte every cycle for single-character bytes and a byte per
//   two characters otherwise; a two-entry queue between the byte front end and
//   the character back end keeps bytes flowing while characters drain
// reset: clears group phase, leftover bits, the queue and the output valid
// stall: while chars is not ready the output holds; the queue fills and then
//   bytes.ready drops until the back end frees an entry
module base64_unpadded_encoder_top
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   bytes,
	b64e_char_if.source chars
);

	q_entry_t     wr_entry;
	q_entry_t     head;
	q_status_t    q_stat;
	back_status_t b_stat;
	logic         push;
	logic         pop;

	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.q_stat (q_stat),
		.push   (push),
		.entry  (wr_entry)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	b64e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.b_stat (b_stat),
		.chars  (chars)
	);

	// a pushed entry must be visible at the queue head side next cycle
	a_push_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> q_stat.head_valid)
		else $error("queue empty after push");

	// the second character of a pair comes from an entry still in the queue
	a_pair_held: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.second_half |-> q_stat.head_valid)
		else $error("second character pending with empty queue");

	// pop only from a non-empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.head_valid)
		else $error("pop from empty queue");

endmodule

>>> rtl/b64e_front.sv
`timescale 1ns / 1ps
module b64e_front
	import b64e_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	b64e_byte_if.sink     bytes,
	input  q_status_t     q_stat,
	output logic          push,
	output q_entry_t      entry
);

	logic [1:0] phase_q;
	logic [3:0] leftover_q;
	logic [1:0] phase_next;
	logic [3:0] leftover_next;
	logic [7:0] b;

	assign b           = bytes.data_byte;
	assign bytes.ready = !q_stat.full;
	assign push        = bytes.valid && !q_stat.full;

	always_comb begin
		entry.eot = bytes.is_last;
		case (phase_q)
			PhaseSecond: begin
				entry.six0    = {leftover_q[1:0], b[7:4]};
				entry.six1    = {b[3:0], 2'b00};
				entry.pair    = bytes.is_last;
				phase_next    = PhaseThird;
				leftover_next = b[3:0];
			end
			PhaseThird: begin
				entry.six0    = {leftover_q, b[7:6]};
				entry.six1    = b[5:0];
				entry.pair    = 1'b1;
				phase_next    = PhaseFirst;
				leftover_next = 4'd0;
			end
			default: begin
				entry.six0    = b[7:2];
				entry.six1    = {b[1:0], 4'b0000};
				entry.pair    = bytes.is_last;
				phase_next    = PhaseSecond;
				leftover_next = {2'b00, b[1:0]};
			end
		endcase
		// end of message starts the next one fresh
		if (bytes.is_last) begin
			phase_next    = PhaseFirst;
			leftover_next = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PhaseFirst;
			leftover_q <= 4'd0;
		end else if (push) begin
			phase_q    <= phase_next;
			leftover_q <= leftover_next;
		end
	end

endmodule

>>> rtl/b64e_queue.sv
`timescale 1ns / 1ps
module b64e_queue
	import b64e_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  wr_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t q_stat
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	q_entry_t          mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign head              = mem_q[rd_ptr_q];
	assign q_stat.head_valid = (count_q != '0);
	assign q_stat.full       = (count_q == CntW'(QueueDepth));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/b64e_back.sv
`timescale 1ns / 1ps
module b64e_back
	import b64e_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  q_entry_t      head,
	input  q_status_t     q_stat,
	output logic          pop,
	output back_status_t  b_stat,
	b64e_char_if.source   chars
);

	logic       sel_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       eot_q;
	logic       load;
	logic       final_char;
	logic [5:0] six;

	assign load       = q_stat.head_valid && (!valid_q || chars.ready);
	assign final_char = !head.pair || sel_q;
	assign six        = sel_q ? head.six1 : head.six0;
	assign pop        = load && final_char;

	assign chars.valid       = valid_q;
	assign chars.char_code   = char_q;
	assign chars.end_of_text = eot_q;
	assign b_stat.second_half = sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !final_char;
			end else if (chars.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= b64e_char(six);
			eot_q  <= final_char && head.eot;
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import b64e_pkg::*;

	localparam int RandomBytes = 600;
	localparam int QuietFrom   = 500;
	localparam int HoldAt      = 300;
	localparam int HoldCycles  = 120;
	localparam int CycleLimit  = 200000;
	localparam logic [511:0] Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] code;
		logic       eot;
	} char_t;

	// n_chars 0: take the characters from the encoder model
	typedef struct {
		logic [7:0] data;
		logic       last;
		int         n_chars;
		logic [6:0] c0;
		logic [6:0] c1;
	} stim_row_t;

	logic clk;
	logic arst_n;

	b64e_byte_if byte_ch ();
	b64e_char_if char_ch ();

	base64_unpadded_encoder_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (byte_ch),
		.chars (char_ch)
	);

	char_t     pending_chars[$];
	stim_row_t stim_rows[$];
	logic [1:0] enc_phase;
	logic [3:0] enc_rest;
	int errors;
	int bytes_sent;
	int random_sent;
	int messages;
	int chars_checked;
	int cycle_count;
	bit quiet;
	bit holding;
	bit hold_done;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [6:0] six_to_ascii(input logic [5:0] six);
		logic [7:0] ch;
		ch = Alphabet[8 * (63 - six) +: 8];
		return ch[6:0];
	endfunction

	task automatic encode_byte(input logic [7:0] b, input logic last, output int n,
			output char_t c0, output char_t c1);
		logic [5:0] s0;
		logic [5:0] s1;
		case (enc_phase)
			PhaseSecond: begin
				s0 = {enc_rest[1:0], b[7:4]};
				s1 = {b[3:0], 2'b00};
				n = last ? 2 : 1;
				enc_phase = PhaseThird;
				enc_rest = b[3:0];
			end
			PhaseThird: begin
				s0 = {enc_rest, b[7:6]};
				s1 = b[5:0];
				n = 2;
				enc_phase = PhaseFirst;
				enc_rest = 4'd0;
			end
			default: begin
				s0 = b[7:2];
				s1 = {b[1:0], 4'b0000};
				n = last ? 2 : 1;
				enc_phase = PhaseSecond;
				enc_rest = {2'b00, b[1:0]};
			end
		endcase
		// a last byte closes the message and restarts the group
		if (last) begin
			enc_phase = PhaseFirst;
			enc_rest = 4'd0;
		end
		c0.code = six_to_ascii(s0);
		c0.eot = 1'b0;
		c1.code = six_to_ascii(s1);
		c1.eot = last;
	endtask

	task automatic push_row(input logic [7:0] data, input logic last, input int n_chars,
			input byte c0, input byte c1);
		stim_row_t row;
		row.data = data;
		row.last = last;
		row.n_chars = n_chars;
		row.c0 = c0[6:0];
		row.c1 = c1[6:0];
		stim_rows.push_back(row);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.is_last <= last;
		@(posedge clk);
		while (!byte_ch.ready) begin
			@(posedge clk);
		end
		bytes_sent++;
		if (last) begin
			messages++;
		end
	endtask

	task automatic sender_gap;
		if (!quiet && !holding && $urandom_range(0, 4) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic run_row(input stim_row_t row);
		int n;
		char_t c0;
		char_t c1;
		send_byte(row.data, row.last);
		encode_byte(row.data, row.last, n, c0, c1);
		if (row.n_chars != 0) begin
			n = row.n_chars;
			c0.code = row.c0;
			c0.eot = (n == 1) ? row.last : 1'b0;
			c1.code = row.c1;
			c1.eot = row.last;
		end
		pending_chars.push_back(c0);
		if (n == 2) begin
			pending_chars.push_back(c1);
		end
		sender_gap();
	endtask

	// character checker
	always @(posedge clk) begin
		char_t want;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character: char_code %0d end_of_text %0d",
					char_ch.char_code, char_ch.end_of_text);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (char_ch.char_code !== want.code) begin
					$error("char_code: expected %0d, actual %0d", want.code, char_ch.char_code);
					errors++;
				end
				if (char_ch.end_of_text !== want.eot) begin
					$error("end_of_text: expected %0d, actual %0d", want.eot,
						char_ch.end_of_text);
					errors++;
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold so the queue fills
	initial begin
		char_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && !quiet && bytes_sent >= HoldAt) begin
				hold_done = 1'b1;
				holding = 1'b1;
				char_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				holding = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				char_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				char_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int len;
		stim_row_t row;
		logic [7:0] b;
		errors = 0;
		bytes_sent = 0;
		random_sent = 0;
		messages = 0;
		chars_checked = 0;
		cycle_count = 0;
		quiet = 1'b0;
		holding = 1'b0;
		hold_done = 1'b0;
		enc_phase = PhaseFirst;
		enc_rest = 4'd0;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		byte_ch.is_last <= 1'b0;

		// single-byte messages, a full group and a two-byte message of extremes, alphabet ends
		push_row(8'h00, 1'b1, 2, "A", "A");
		push_row(8'hFF, 1'b1, 2, "/", "w");
		push_row(8'hFF, 1'b0, 1, "/", 0);
		push_row(8'hFF, 1'b0, 1, "/", 0);
		push_row(8'hFF, 1'b1, 2, "/", "/");
		push_row(8'h00, 1'b0, 1, "A", 0);
		push_row(8'h00, 1'b1, 2, "A", "A");
		push_row(8'h4D, 1'b0, 0, 0, 0);
		push_row(8'h61, 1'b0, 0, 0, 0);
		push_row(8'h6E, 1'b1, 0, 0, 0);
		push_row(8'hF8, 1'b1, 2, "+", "A");
		// five bytes: flush after the second position
		push_row(8'h12, 1'b0, 0, 0, 0);
		push_row(8'h34, 1'b0, 0, 0, 0);
		push_row(8'h56, 1'b0, 0, 0, 0);
		push_row(8'h78, 1'b0, 0, 0, 0);
		push_row(8'h9A, 1'b1, 0, 0, 0);
		// walking one across two full groups and two more bytes
		for (int i = 0; i < 8; i++) begin
			push_row(8'h01 << i, i == 7, 0, 0, 0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			run_row(stim_rows[i]);
		end

		while (random_sent < RandomBytes) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 15))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				row.data = b;
				row.last = (k == len - 1);
				row.n_chars = 0;
				row.c0 = 7'd0;
				row.c1 = 7'd0;
				run_row(row);
				random_sent++;
				if (random_sent >= QuietFrom) begin
					quiet = 1'b1;
				end
			end
		end
		byte_ch.valid <= 1'b0;

		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("encoded %0d bytes in %0d messages, %0d characters checked",
			bytes_sent, messages, chars_checked);
		$display("output stalls, input gaps and one long output hold exercised");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
